[sv/integer_to_ascii_formatter_core_defines.svh]
// Assertion macros shared by the integer-to-ASCII formatter modules.
// Each user module must have i_clk and i_rst_n in scope.
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define INTFMT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("intfmt same-cycle check failed");

// Next-cycle implication, checked outside reset
`define INTFMT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("intfmt next-cycle check failed");

`endif

[sv/intfmt_pkg.sv]
// Types and constants for the integer-to-ASCII formatter.
// Depends on nothing; used by intfmt_ctrl, intfmt_dp and the top level.
`default_nettype none

package intfmt_pkg;

    // Radix modes
    localparam logic [1:0] CMD_SDEC = 2'd0;
    localparam logic [1:0] CMD_UDEC = 2'd1;
    localparam logic [1:0] CMD_HEX  = 2'd2;
    localparam logic [1:0] CMD_OCT  = 2'd3;

    // Most digits a 32-bit value can take (octal)
    localparam int DIG_MAX = 11;
    localparam int DIG_AW  = 4;

    // Reciprocal of ten, exact for 32-bit dividends with a shift of 35
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
    localparam int          RECIP_SH = 35;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] value;
        logic [5:0]  field_width;
        logic        zero_pad;
        logic        alt_prefix;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } t_out_beat;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic conv_done;
        logic slot_free;
        logic last_char;
    } t_dp_stat;

    // Map a digit value to its upper-case ASCII character
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] r;
        if (d > 4'h9) begin
            r = CH_UPA + {4'h0, d} - 8'h0A;
        end else begin
            r = CH_ZERO + {4'h0, d};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/integer_to_ascii_formatter_core.sv]
// Integer-to-ASCII formatter: one number in, one character per beat out,
// most significant first, with last on the final character.
// Uses intfmt_pkg, intfmt_ctrl and intfmt_dp.
//
// An item is accepted, then one digit is extracted per cycle (at most
// 11, and at most the field width when that is nonzero), then one output
// character is emitted per cycle while the sink does not stall: prefix or
// minus sign, padding and digits, at most MAX_WIDTH + 2 characters. A new
// item is taken in the cycle after the last character enters the output
// register, so one item is fully done before the next is taken, as set by
// the single digit extractor and the one-character output register.
`default_nettype none

module integer_to_ascii_formatter_core #(
    parameter int MAX_WIDTH = 32
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_stall,
    input  wire intfmt_pkg::t_in_beat i_in,
    output logic                      o_out_valid,
    input  wire                       i_out_stall,
    output intfmt_pkg::t_out_beat     o_out
);

    intfmt_pkg::t_dp_cmd  dp_cmd;
    intfmt_pkg::t_dp_stat dp_stat;

    intfmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    intfmt_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

[sv/intfmt_ctrl.sv]
// Sequencing state machine of the integer-to-ASCII formatter.
// Uses intfmt_pkg and the assertion macros header; drives intfmt_dp.
`default_nettype none
`include "integer_to_ascii_formatter_core_defines.svh"

module intfmt_ctrl (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_stall,
    input  wire intfmt_pkg::t_dp_stat i_stat,
    output intfmt_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    t_state r_state;
    logic   r_in_stall;

    // Issue datapath commands from the current state
    always_comb begin
        o_cmd.load = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.step = (r_state == ST_CONV);
        o_cmd.emit = (r_state == ST_EMIT) && i_stat.slot_free;
    end

    assign o_in_stall = r_in_stall;

    // Advance state; hold input stall while an item is in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= ST_CONV;
                        r_in_stall <= 1'b1;
                    end
                end
                ST_CONV: begin
                    if (i_stat.conv_done) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (i_stat.slot_free && i_stat.last_char) begin
                        r_state    <= ST_IDLE;
                        r_in_stall <= 1'b0;
                    end
                end
                default: begin
                    r_state    <= ST_IDLE;
                    r_in_stall <= 1'b0;
                end
            endcase
        end
    end

    `INTFMT_ASSERT_NOW(a_stall_idle, 1'b1, (r_state == ST_IDLE) == !r_in_stall)
    `INTFMT_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(o_cmd))
    `INTFMT_ASSERT_NEXT(a_load_conv, o_cmd.load, r_state == ST_CONV)
    `INTFMT_ASSERT_NEXT(a_last_idle, o_cmd.emit && i_stat.last_char, r_state == ST_IDLE)

endmodule

`default_nettype wire

[sv/intfmt_dp.sv]
// Datapath of the integer-to-ASCII formatter: digit extraction, digit
// buffer, character select and output register. Uses intfmt_pkg and the
// assertion macros header.
`default_nettype none
`include "integer_to_ascii_formatter_core_defines.svh"

module intfmt_dp #(
    parameter int MAX_WIDTH = 32
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire intfmt_pkg::t_in_beat i_in,
    input  wire intfmt_pkg::t_dp_cmd  i_cmd,
    output intfmt_pkg::t_dp_stat      o_stat,
    output logic                      o_out_valid,
    input  wire                       i_out_stall,
    output intfmt_pkg::t_out_beat     o_out
);

    localparam int WW = $clog2(MAX_WIDTH + 1);

    // Item state
    logic [1:0]                    r_mode;
    logic [31:0]                   r_val;
    logic [WW-1:0]                 r_w;
    logic                          r_zp;
    logic                          r_neg;
    logic [1:0]                    r_head;
    logic [intfmt_pkg::DIG_AW-1:0] r_ndig;
    logic [WW-1:0]                 r_pos;
    logic [3:0]                    r_dig [intfmt_pkg::DIG_MAX];

    // Output register
    logic                  r_ovalid;
    intfmt_pkg::t_out_beat r_out;

    // Load-time values
    logic          ld_neg;
    logic [WW-1:0] ld_w;
    logic [1:0]    ld_head;

    // Digit step
    logic [63:0]                   prod;
    logic [28:0]                   quo10;
    logic [31:0]                   q10;
    logic [31:0]                   rem10;
    logic [3:0]                    digit;
    logic [31:0]                   nval;
    logic [intfmt_pkg::DIG_AW-1:0] ndig_inc;
    logic                          conv_done;

    // Character select
    logic [7:0] head_ch;
    logic [7:0] body_ch;
    logic [7:0] cur_ch;

    always_comb begin
        ld_neg = (i_in.cmd == intfmt_pkg::CMD_SDEC) && i_in.value[31];
        if (32'(i_in.field_width) > MAX_WIDTH) begin
            ld_w = WW'(MAX_WIDTH);
        end else begin
            ld_w = WW'(i_in.field_width);
        end
        if (i_in.alt_prefix && i_in.cmd == intfmt_pkg::CMD_HEX) begin
            ld_head = 2'd2;
        end else if (i_in.alt_prefix && i_in.cmd == intfmt_pkg::CMD_OCT) begin
            ld_head = 2'd1;
        end else if (ld_neg) begin
            ld_head = 2'd1;
        end else begin
            ld_head = 2'd0;
        end
    end

    // Extract one digit per cycle; decimal uses the reciprocal of ten
    always_comb begin
        prod  = {32'h0, r_val} * {32'h0, intfmt_pkg::RECIP10};
        quo10 = prod[63:intfmt_pkg::RECIP_SH];
        q10   = {quo10[28:0], 3'b000} + {2'b00, quo10[28:0], 1'b0};
        rem10 = r_val - q10;
        case (r_mode)
            intfmt_pkg::CMD_HEX: begin
                digit = r_val[3:0];
                nval  = {4'h0, r_val[31:4]};
            end
            intfmt_pkg::CMD_OCT: begin
                digit = {1'b0, r_val[2:0]};
                nval  = {3'h0, r_val[31:3]};
            end
            default: begin
                digit = rem10[3:0];
                nval  = {3'h0, quo10};
            end
        endcase
        ndig_inc  = r_ndig + 1'b1;
        conv_done = (nval == 32'h0) || ((r_w != '0) && (WW'(ndig_inc) == r_w));
    end

    // Pick prefix, sign, padding or digit for the next character
    always_comb begin
        if (r_neg) begin
            head_ch = intfmt_pkg::CH_MINUS;
        end else if (r_mode == intfmt_pkg::CMD_HEX && r_head == 2'd1) begin
            head_ch = intfmt_pkg::CH_X;
        end else begin
            head_ch = intfmt_pkg::CH_ZERO;
        end
        if (r_pos < WW'(r_ndig)) begin
            body_ch = intfmt_pkg::digit_char(r_dig[r_pos[intfmt_pkg::DIG_AW-1:0]]);
        end else if (r_zp) begin
            body_ch = intfmt_pkg::CH_ZERO;
        end else begin
            body_ch = intfmt_pkg::CH_SPACE;
        end
        cur_ch           = (r_head != 2'd0) ? head_ch : body_ch;
        o_stat.conv_done = conv_done;
        o_stat.last_char = (r_head == 2'd0) && (r_pos == '0);
        o_stat.slot_free = !r_ovalid || !i_out_stall;
    end

    // Load item, collect digits, walk the emit sequence
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_in.cmd;
            r_val  <= ld_neg ? (~i_in.value + 32'h1) : i_in.value;
            r_w    <= ld_w;
            r_zp   <= i_in.zero_pad;
            r_neg  <= ld_neg;
            r_head <= ld_head;
            r_ndig <= '0;
        end else if (i_cmd.step) begin
            r_dig[r_ndig] <= digit;
            r_ndig        <= ndig_inc;
            r_val         <= nval;
            if (conv_done) begin
                r_pos <= (r_w == '0) ? WW'(r_ndig) : (r_w - 1'b1);
            end
        end else if (i_cmd.emit) begin
            if (r_head != 2'd0) begin
                r_head <= r_head - 2'd1;
            end else begin
                r_pos <= r_pos - 1'b1;
            end
        end
    end

    // Hold the beat until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.out_char <= cur_ch;
            r_out.last     <= o_stat.last_char;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    `INTFMT_ASSERT_NOW(a_dig_room, i_cmd.step, r_ndig < intfmt_pkg::DIG_AW'(intfmt_pkg::DIG_MAX))
    `INTFMT_ASSERT_NOW(a_emit_free, i_cmd.emit, !r_ovalid || !i_out_stall)
    `INTFMT_ASSERT_NEXT(a_last_flag, i_cmd.emit && o_stat.last_char, r_ovalid && r_out.last)

endmodule

`default_nettype wire
